### rtl/ptrs_pkg.sv
// Shared types and constants for the point translate, rotate and scale block.
`default_nettype none
package ptrs_pkg;

    localparam int CoefW = 30;                  // matrix entry, signed Q2.28
    localparam int FracR = 28;
    localparam int NumEntries = 9;
    localparam int QuoBits = 29;

    localparam logic [CoefW-1:0] CoefOne = CoefW'(1) << FracR;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ROT_W   = 3'd0;
    localparam logic [2:0] REG_ROT_X   = 3'd1;
    localparam logic [2:0] REG_ROT_Y   = 3'd2;
    localparam logic [2:0] REG_ROT_Z   = 3'd3;
    localparam logic [2:0] REG_SHIFT_X = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y = 3'd5;
    localparam logic [2:0] REG_SHIFT_Z = 3'd6;
    localparam logic [2:0] REG_SCALE   = 3'd7;

    typedef logic signed [CoefW-1:0] coef_t;
    typedef coef_t [NumEntries-1:0] mat_t;

    typedef struct packed {
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic signed [31:0] scale;
    } cfg_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PROD,
        SEQ_SUM,
        SEQ_LOAD,
        SEQ_DIV
    } seq_state_t;

endpackage
`default_nettype wire

### rtl/ptrs_cfg.sv
// APB register file holding the quaternion, translation and scale.
`default_nettype none
module ptrs_cfg
    import ptrs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg,
    output logic             rot_wr
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;
    assign rot_wr = wr_en && !idx[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_w   <= 16'sd16384;
            cfg_reg.rot_x   <= '0;
            cfg_reg.rot_y   <= '0;
            cfg_reg.rot_z   <= '0;
            cfg_reg.shift_x <= '0;
            cfg_reg.shift_y <= '0;
            cfg_reg.shift_z <= '0;
            cfg_reg.scale   <= 32'sd65536;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ROT_W:   cfg_reg.rot_w   <= pwdata[15:0];
                REG_ROT_X:   cfg_reg.rot_x   <= pwdata[15:0];
                REG_ROT_Y:   cfg_reg.rot_y   <= pwdata[15:0];
                REG_ROT_Z:   cfg_reg.rot_z   <= pwdata[15:0];
                REG_SHIFT_X: cfg_reg.shift_x <= pwdata;
                REG_SHIFT_Y: cfg_reg.shift_y <= pwdata;
                REG_SHIFT_Z: cfg_reg.shift_z <= pwdata;
                REG_SCALE:   cfg_reg.scale   <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ROT_W:   prdata = {{16{cfg_reg.rot_w[15]}}, cfg_reg.rot_w};
            REG_ROT_X:   prdata = {{16{cfg_reg.rot_x[15]}}, cfg_reg.rot_x};
            REG_ROT_Y:   prdata = {{16{cfg_reg.rot_y[15]}}, cfg_reg.rot_y};
            REG_ROT_Z:   prdata = {{16{cfg_reg.rot_z[15]}}, cfg_reg.rot_z};
            REG_SHIFT_X: prdata = cfg_reg.shift_x;
            REG_SHIFT_Y: prdata = cfg_reg.shift_y;
            REG_SHIFT_Z: prdata = cfg_reg.shift_z;
            REG_SCALE:   prdata = cfg_reg.scale;
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/ptrs_mat.sv
// Rotation matrix sequencer: builds M(q)/n with one restoring divider.
`default_nettype none
module ptrs_mat
    import ptrs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic rot_wr,
    output mat_t      mat,
    output logic      busy
);

    seq_state_t state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [4:0] cnt_reg, cnt_next;

    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [33:0] m_reg [NumEntries];
    logic        [32:0] n_reg;
    logic        [32:0] rem_reg;
    logic [QuoBits-1:0] low_reg;
    logic [QuoBits-1:0] quo_reg;
    logic               neg_reg;
    mat_t               mat_reg;

    logic signed [33:0] e_ww, e_xx, e_yy, e_zz;
    logic signed [33:0] e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
    logic signed [33:0] n_sum;
    logic signed [33:0] m_sel;
    logic        [32:0] mag;
    logic        [61:0] num;
    logic        [33:0] rem_sh;
    logic               ge;
    logic [QuoBits-1:0] quo_next;
    logic        [CoefW-1:0] quo_ext;

    assign mat  = mat_reg;
    assign busy = (state_reg != SEQ_IDLE);

    assign e_ww = {{2{ww_reg[31]}}, ww_reg};
    assign e_xx = {{2{xx_reg[31]}}, xx_reg};
    assign e_yy = {{2{yy_reg[31]}}, yy_reg};
    assign e_zz = {{2{zz_reg[31]}}, zz_reg};
    assign e_xy = {{2{xy_reg[31]}}, xy_reg};
    assign e_xz = {{2{xz_reg[31]}}, xz_reg};
    assign e_yz = {{2{yz_reg[31]}}, yz_reg};
    assign e_wx = {{2{wx_reg[31]}}, wx_reg};
    assign e_wy = {{2{wy_reg[31]}}, wy_reg};
    assign e_wz = {{2{wz_reg[31]}}, wz_reg};
    assign n_sum = e_ww + e_xx + e_yy + e_zz;

    // Quotient stays below 2^29, so the top of the numerator is already below n.
    assign m_sel = m_reg[idx_reg];
    assign mag   = m_sel[33] ? 33'(-m_sel) : m_sel[32:0];
    assign num   = {1'b0, mag, 28'd0} + {30'd0, n_reg[32:1]};

    assign rem_sh   = {rem_reg, low_reg[QuoBits-1]};
    assign ge       = (rem_sh >= {1'b0, n_reg});
    assign quo_next = {quo_reg[QuoBits-2:0], ge};
    assign quo_ext  = {1'b0, quo_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            SEQ_IDLE: ;
            SEQ_PROD: state_next = SEQ_SUM;
            SEQ_SUM:
            begin
                idx_next   = '0;
                state_next = (n_sum == '0) ? SEQ_IDLE : SEQ_LOAD;
            end
            SEQ_LOAD:
            begin
                cnt_next   = '0;
                state_next = SEQ_DIV;
            end
            SEQ_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QuoBits - 1))
                begin
                    idx_next = idx_reg + 4'd1;
                    state_next = (idx_reg == 4'(NumEntries - 1)) ? SEQ_IDLE : SEQ_LOAD;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
        // restart on any quaternion write
        if (rot_wr)
        begin
            state_next = SEQ_PROD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NumEntries; k++)
            begin
                mat_reg[k] <= ((k % 4) == 0) ? CoefOne : '0;
            end
        end
        else if (state_reg == SEQ_SUM && n_sum == '0 && !rot_wr)
        begin
            for (int k = 0; k < NumEntries; k++)
            begin
                mat_reg[k] <= ((k % 4) == 0) ? CoefOne : '0;
            end
        end
        else if (state_reg == SEQ_DIV && cnt_reg == 5'(QuoBits - 1) && !rot_wr)
        begin
            mat_reg[idx_reg] <= neg_reg ? -quo_ext : quo_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            SEQ_PROD:
            begin
                ww_reg <= cfg.rot_w * cfg.rot_w;
                xx_reg <= cfg.rot_x * cfg.rot_x;
                yy_reg <= cfg.rot_y * cfg.rot_y;
                zz_reg <= cfg.rot_z * cfg.rot_z;
                xy_reg <= cfg.rot_x * cfg.rot_y;
                xz_reg <= cfg.rot_x * cfg.rot_z;
                yz_reg <= cfg.rot_y * cfg.rot_z;
                wx_reg <= cfg.rot_w * cfg.rot_x;
                wy_reg <= cfg.rot_w * cfg.rot_y;
                wz_reg <= cfg.rot_w * cfg.rot_z;
            end
            SEQ_SUM:
            begin
                n_reg   <= n_sum[32:0];
                m_reg[0] <= e_ww + e_xx - e_yy - e_zz;
                m_reg[1] <= (e_xy - e_wz) <<< 1;
                m_reg[2] <= (e_xz + e_wy) <<< 1;
                m_reg[3] <= (e_xy + e_wz) <<< 1;
                m_reg[4] <= e_ww - e_xx + e_yy - e_zz;
                m_reg[5] <= (e_yz - e_wx) <<< 1;
                m_reg[6] <= (e_xz - e_wy) <<< 1;
                m_reg[7] <= (e_yz + e_wx) <<< 1;
                m_reg[8] <= e_ww - e_xx - e_yy + e_zz;
            end
            SEQ_LOAD:
            begin
                rem_reg <= num[61:29];
                low_reg <= num[28:0];
                quo_reg <= '0;
                neg_reg <= m_sel[33];
            end
            SEQ_DIV:
            begin
                rem_reg <= ge ? 33'(rem_sh - {1'b0, n_reg}) : rem_sh[32:0];
                low_reg <= {low_reg[QuoBits-2:0], 1'b0};
                quo_reg <= quo_next;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### rtl/ptrs_pipe.sv
// Six-stage point datapath: translate, matrix multiply, sum, round, scale, saturate.
`default_nettype none
module ptrs_pipe
    import ptrs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic               last_in,
    input  wire cfg_t               cfg,
    input  wire mat_t               mat,
    output logic                    done,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic                    last_out
);

    logic [6:1] vld_reg;
    logic [6:1] last_reg;

    logic signed [32:0] v_reg    [3];
    logic signed [62:0] prod_reg [NumEntries];
    logic signed [64:0] acc_reg  [3];
    logic        [32:0] mr_reg   [3];
    logic        [2:0]  rneg_reg;
    logic        [64:0] sp_reg   [3];
    logic        [2:0]  sneg_reg;
    logic signed [31:0] res_reg  [3];

    logic signed [31:0] pin [3];
    logic signed [31:0] tin [3];
    logic        [31:0] ms;

    assign pin[0] = point_x;
    assign pin[1] = point_y;
    assign pin[2] = point_z;
    assign tin[0] = cfg.shift_x;
    assign tin[1] = cfg.shift_y;
    assign tin[2] = cfg.shift_z;
    assign ms     = cfg.scale[31] ? -cfg.scale : cfg.scale;

    assign done     = vld_reg[6];
    assign last_out = last_reg[6];
    assign out_x    = res_reg[0];
    assign out_y    = res_reg[1];
    assign out_z    = res_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[5:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[5:1], last_in};
    end

    // Translate, kept exact in 33 bits.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_reg[i] <= {pin[i][31], pin[i]} + {tin[i][31], tin[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NumEntries; k++)
        begin
            prod_reg[k] <= $signed(mat[k]) * v_reg[k % 3];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_reg[i] <= {{2{prod_reg[3*i][62]}},   prod_reg[3*i]}
                        + {{2{prod_reg[3*i+1][62]}}, prod_reg[3*i+1]}
                        + {{2{prod_reg[3*i+2][62]}}, prod_reg[3*i+2]};
        end
    end

    // Round the product of the Q2.28 matrix half away from zero, clamp the magnitude.
    always_ff @(posedge clk)
    begin
        logic [64:0] amag;
        logic [36:0] q;
        for (int i = 0; i < 3; i++)
        begin
            amag = acc_reg[i][64] ? 65'(-acc_reg[i]) : acc_reg[i];
            q    = 37'((amag + (65'(1) << (FracR - 1))) >> FracR);
            mr_reg[i]   <= (q[36:33] != '0) ? '1 : q[32:0];
            rneg_reg[i] <= acc_reg[i][64];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sp_reg[i]   <= mr_reg[i] * ms;
            sneg_reg[i] <= rneg_reg[i] ^ cfg.scale[31];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [65:0] sr;
        logic [49:0] q;
        for (int i = 0; i < 3; i++)
        begin
            sr = {1'b0, sp_reg[i]} + 66'd32768;
            q  = sr[65:16];
            if (!sneg_reg[i])
            begin
                res_reg[i] <= (q > 50'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
            end
            else
            begin
                res_reg[i] <= (q > 50'h80000000) ? 32'sh80000000 : -q[31:0];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/point_translate_rotate_scale.sv
// Top level: translate, quaternion rotate and scale a stream of Q16.16 points.
//
// One point enters per cycle while busy is low; its result appears on out_x/y/z
// with done high for one cycle. The receiver cannot stall the output. A write to
// any quaternion register starts the matrix sequencer, which raises busy while one
// shared restoring divider forms the nine normalized matrix entries; a zero
// quaternion gives the identity without dividing. Reset loads the identity matrix
// at once.
`default_nettype none
module point_translate_rotate_scale
    import ptrs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic               last_in,
    output logic                    done,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic                    last_out
);

    cfg_t cfg;
    logic rot_wr;
    mat_t mat;

    ptrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .rot_wr  (rot_wr)
    );

    ptrs_mat u_mat (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .rot_wr (rot_wr),
        .mat    (mat),
        .busy   (busy)
    );

    ptrs_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .last_in  (last_in),
        .cfg      (cfg),
        .mat      (mat),
        .done     (done),
        .out_x    (out_x),
        .out_y    (out_y),
        .out_z    (out_z),
        .last_out (last_out)
    );

endmodule
`default_nettype wire

### test/tb_point_translate_rotate_scale.sv
// Testbench for point_translate_rotate_scale: directed table, random points, config sweeps.
`timescale 1ns / 100ps
module tb_point_translate_rotate_scale
    import ptrs_pkg::*;
();

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } point_t;

    typedef struct {
        point_t p;
        int     phase;     // config set applied before this row
        bit     typed;     // expected value given in the row
        point_t want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_in;
    logic               done;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               last_out;

    // shadow of the block's registers
    logic signed [15:0] q_w, q_x, q_y, q_z;
    logic signed [31:0] t_x, t_y, t_z, gain;

    point_t pending_points[$];
    row_t   dir_rows[$];
    bit     typed_now;
    point_t typed_val;
    int     errors;
    int     cycles;

    point_translate_rotate_scale dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .point_z(point_z), .last_in(last_in),
        .done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z), .last_out(last_out)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint abs64(longint a);
        return a < 0 ? -a : a;
    endfunction

    // normalized matrix entry, Q2.28, rounded half away from zero
    function automatic longint norm_entry(longint m, longint n);
        longint q;
        q = ((abs64(m) << FracR) + n / 2) / n;
        return m < 0 ? -q : q;
    endfunction

    function automatic longint round_q28(longint a);
        longint q;
        q = (abs64(a) + (64'sd1 <<< (FracR - 1))) >>> FracR;
        return a < 0 ? -q : q;
    endfunction

    function automatic logic signed [31:0] scale_clip(longint r);
        longint clamp;
        longint unsigned mr, ms, q;
        bit neg;
        clamp = 64'sd8589934591;
        if (r > clamp) r = clamp;
        if (r < -clamp) r = -clamp;
        mr = abs64(r);
        ms = abs64(longint'(gain));
        neg = (r < 0) != (gain < 0);
        q = (mr * ms + 64'd32768) >> 16;
        if (!neg)
            return q > 64'd2147483647 ? 32'sh7fffffff : 32'(q);
        else
            return q > 64'd2147483648 ? 32'sh80000000 : 32'(-longint'(q));
    endfunction

    function automatic point_t transform_point(point_t p);
        longint w, x, y, z, ww, xx, yy, zz, n, acc;
        longint m[9];
        longint v[3];
        point_t o;
        w = q_w; x = q_x; y = q_y; z = q_z;
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        n = ww + xx + yy + zz;
        v[0] = longint'(p.x) + longint'(t_x);
        v[1] = longint'(p.y) + longint'(t_y);
        v[2] = longint'(p.z) + longint'(t_z);
        if (n == 0)
        begin
            foreach (m[i]) m[i] = (i % 4 == 0) ? (64'sd1 <<< FracR) : 0;
        end
        else
        begin
            m[0] = ww + xx - yy - zz;
            m[1] = 2 * (x * y - w * z);
            m[2] = 2 * (x * z + w * y);
            m[3] = 2 * (x * y + w * z);
            m[4] = ww - xx + yy - zz;
            m[5] = 2 * (y * z - w * x);
            m[6] = 2 * (x * z - w * y);
            m[7] = 2 * (y * z + w * x);
            m[8] = ww - xx - yy + zz;
            foreach (m[i]) m[i] = norm_entry(m[i], n);
        end
        acc = m[0] * v[0] + m[1] * v[1] + m[2] * v[2];
        o.x = scale_clip(round_q28(acc));
        acc = m[3] * v[0] + m[4] * v[1] + m[5] * v[2];
        o.y = scale_clip(round_q28(acc));
        acc = m[6] * v[0] + m[7] * v[1] + m[8] * v[2];
        o.z = scale_clip(round_q28(acc));
        o.last = p.last;
        return o;
    endfunction

    // capture requests and check results
    always @(posedge clk)
    begin
        point_t w, p;
        cycles <= cycles + 1;
        if (rst_n && start && !busy)
        begin
            p.x = point_x; p.y = point_y; p.z = point_z; p.last = last_in;
            w = typed_now ? typed_val : transform_point(p);
            pending_points.insert(pending_points.size(), w);
        end
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h z=%h", $time, out_x, out_y, out_z);
                errors++;
            end
            else
            begin
                w = pending_points.pop_front();
                if (out_x !== w.x)
                begin
                    $display("%0t: out_x expected %h actual %h", $time, w.x, out_x);
                    errors++;
                end
                if (out_y !== w.y)
                begin
                    $display("%0t: out_y expected %h actual %h", $time, w.y, out_y);
                    errors++;
                end
                if (out_z !== w.z)
                begin
                    $display("%0t: out_z expected %h actual %h", $time, w.z, out_z);
                    errors++;
                end
                if (last_out !== w.last)
                begin
                    $display("%0t: last_out expected %b actual %b", $time, w.last, last_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > 400000)
        begin
            $display("tb_point_translate_rotate_scale NOT OK");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_points.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_ROT_W:   q_w = val[15:0];
            REG_ROT_X:   q_x = val[15:0];
            REG_ROT_Y:   q_y = val[15:0];
            REG_ROT_Z:   q_z = val[15:0];
            REG_SHIFT_X: t_x = val;
            REG_SHIFT_Y: t_y = val;
            REG_SHIFT_Z: t_z = val;
            default:     gain = val;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // let the matrix sequencer pick up the new quaternion
        repeat (3) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_all(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                             logic [31:0] g);
        write_reg(REG_ROT_W, {{16{w[15]}}, w});
        write_reg(REG_ROT_X, {{16{x[15]}}, x});
        write_reg(REG_ROT_Y, {{16{y[15]}}, y});
        write_reg(REG_ROT_Z, {{16{z[15]}}, z});
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
        write_reg(REG_SHIFT_Z, sz);
        write_reg(REG_SCALE, g);
    endtask

    // hold the request until accepted; start stays high for a following request
    task automatic send_point(point_t p, bit typed, point_t want, bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 18)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        point_x <= p.x;
        point_y <= p.y;
        point_z <= p.z;
        last_in <= p.last;
        typed_now <= typed;
        typed_val <= want;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic add_row(int phase, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           bit last, bit typed);
        row_t r;
        r.phase = phase;
        r.p.x = x; r.p.y = y; r.p.z = z; r.p.last = last;
        r.typed = typed;
        r.want = r.p;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h7fffffff - $urandom_range(0, 3);
            2:       return 32'h80000000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h01ffffff) - 32'h01000000;
        endcase
    endfunction

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return 32'h80000000;
            1:       return 32'h7fffffff;
            2:       return $urandom;
            default: return $urandom_range(0, 32'h00040000) - 32'h00020000;
        endcase
    endfunction

    initial
    begin
        point_t p, none;
        int phase;
        bit calm;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        start = 1'b0; point_x = '0; point_y = '0; point_z = '0; last_in = 1'b0;
        typed_now = 1'b0; typed_val = '{default: '0};
        none = '{default: '0};
        errors = 0; cycles = 0;
        q_w = 16'sd16384; q_x = 0; q_y = 0; q_z = 0;
        t_x = 0; t_y = 0; t_z = 0; gain = 32'sd65536;

        // reset values: identity at unit scale passes points through
        add_row(0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
        add_row(0, 32'h1, 32'hffffffff, 32'h7fffffff, 1'b1, 1'b1);
        add_row(0, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, 1'b1);
        add_row(0, 32'h00010000, 32'hfffe8000, 32'h12345678, 1'b1, 1'b1);
        // quarter turn about z, shifted
        add_row(1, 32'h00010000, 32'h0, 32'h0, 1'b0, 1'b0);
        add_row(1, 32'h0, 32'h00020000, 32'hfff00000, 1'b1, 1'b0);
        add_row(1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0, 1'b0);
        // zero quaternion, negative unit scale
        add_row(2, 32'h00030000, 32'h00000001, 32'hffffffff, 1'b0, 1'b0);
        add_row(2, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1, 1'b0);
        // extremes everywhere, unnormalized quaternion
        add_row(3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0);
        add_row(3, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b0);
        add_row(3, 32'h00000001, 32'h00000000, 32'hffffffff, 1'b0, 1'b0);
        // tiny quaternion, fractional scale
        add_row(4, 32'h00018000, 32'hfffe8000, 32'h00008000, 1'b0, 1'b0);
        add_row(4, 32'h00000001, 32'h00000001, 32'hffffffff, 1'b1, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        phase = 0;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].phase != phase)
            begin
                start <= 1'b0;
                phase = dir_rows[i].phase;
                case (phase)
                    1: write_all(16'sd11585, 0, 0, 16'sd11585,
                                 32'h00010000, 32'hffff0000, 32'h00000100, 32'h00010000);
                    2: write_all(0, 0, 0, 0, 0, 0, 0, 32'hffff0000);
                    3: write_all(16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
                    default: write_all(16'sd1, 16'sd2, 16'hffff, 16'sd3,
                                       32'h00000003, 32'hfffffffd, 0, 32'h00008001);
                endcase
            end
            send_point(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].want, 1'b1);
        end

        for (int k = 0; k < 450; k++)
        begin
            if (k % 75 == 0)
            begin
                start <= 1'b0;
                write_all(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                          rand_coord(), rand_coord(), rand_coord(), rand_gain());
            end
            if (k == 320)
            begin
                // drain before going on
                start <= 1'b0;
                while (pending_points.size() != 0) @(posedge clk);
            end
            p.x = rand_coord(); p.y = rand_coord(); p.z = rand_coord();
            p.last = $urandom_range(0, 1);
            calm = (k >= 160 && k < 240);
            send_point(p, 1'b0, none, !calm);
        end
        start <= 1'b0;

        while (pending_points.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_point_translate_rotate_scale OK");
        else
            $display("tb_point_translate_rotate_scale NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/ptrs_pkg.sv
rtl/ptrs_cfg.sv
rtl/ptrs_mat.sv
rtl/ptrs_pipe.sv
rtl/point_translate_rotate_scale.sv
test/tb_point_translate_rotate_scale.sv
